@@ rtl/length_command_checksum_framer_unit_assert.svh @@
// assertion macros shared by the framer rtl
// no dependencies; included by the modules that check their own logic
`ifndef LENGTH_COMMAND_CHECKSUM_FRAMER_UNIT_ASSERT_SVH
`define LENGTH_COMMAND_CHECKSUM_FRAMER_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define LCCF_ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
		else $error("lccf assertion failed");

// condition implies consequence in the next cycle
`define LCCF_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
		else $error("lccf assertion failed");

`endif

@@ rtl/lccf_pkg.sv @@
// types and constants for the length/command/checksum framer
// no dependencies; used by the front end, queue, back end and top rtl files
`timescale 1ns / 1ps

package lccf_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int JOB_BYTES = 4;
	localparam int IDX_W = 2;

	localparam logic [16:0] HDR_EXTRA = 17'd4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BUSY      = 2'd1,
		ST_SIZE      = 2'd2,
		ST_IDLE_DATA = 2'd3
	} status_t;

	// one queued job: up to four bytes sent in order, same status on all
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [IDX_W-1:0]          last_idx;
		logic                      end_on_last;
		status_t                   status;
	} job_t;

endpackage

@@ rtl/lccf_if.sv @@
// request channel interfaces for the framer input and output streams
// no dependencies
`timescale 1ns / 1ps

interface lccf_in_if;
	logic        valid;
	logic        ready;
	logic        start_req;
	logic [7:0]  command;
	logic [15:0] payload_len;
	logic [7:0]  data_byte;

	modport source(output valid, output start_req, output command, output payload_len,
		output data_byte, input ready);
	modport sink(input valid, input start_req, input command, input payload_len,
		input data_byte, output ready);
endinterface

interface lccf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic [1:0] status;

	modport source(output valid, output out_byte, output frame_end, output status,
		input ready);
	modport sink(input valid, input out_byte, input frame_end, input status,
		output ready);
endinterface

@@ rtl/lccf_front.sv @@
// front end: accepts input requests, tracks frame state, builds output jobs
// depends on lccf_pkg, lccf_if and the assertion macro header
`timescale 1ns / 1ps
`include "length_command_checksum_framer_unit_assert.svh"

module lccf_front (
	input  logic                clk,
	input  logic                arst_n,
	lccf_in_if.sink             in_chan,
	input  logic                full,
	output logic                push,
	output lccf_pkg::job_t      job
);

	logic        in_frame_q;
	logic [15:0] bytes_left_q;
	logic [7:0]  running_sum_q;

	logic        in_frame_d;
	logic [15:0] bytes_left_d;
	logic [7:0]  running_sum_d;

	logic [16:0] total;
	logic [7:0]  sum_data;
	logic [15:0] left_dec;
	logic        accept;

	assign in_chan.ready = !full;
	assign accept        = in_chan.valid && !full;
	assign push          = accept;

	assign total    = {1'b0, in_chan.payload_len} + lccf_pkg::HDR_EXTRA;
	assign sum_data = running_sum_q + in_chan.data_byte;
	assign left_dec = bytes_left_q - 16'd1;

	always_comb begin
		in_frame_d      = in_frame_q;
		bytes_left_d    = bytes_left_q;
		running_sum_d   = running_sum_q;
		job.bytes       = '0;
		job.last_idx    = '0;
		job.end_on_last = 1'b1;
		job.status      = lccf_pkg::ST_OK;
		if (in_chan.start_req) begin
			if (in_frame_q) begin
				job.status = lccf_pkg::ST_BUSY;
			end else if (total[16]) begin
				job.status = lccf_pkg::ST_SIZE;
			end else begin
				job.bytes[0] = total[15:8];
				job.bytes[1] = total[7:0];
				job.bytes[2] = in_chan.command;
				bytes_left_d = in_chan.payload_len;
				if (in_chan.payload_len == 16'd0) begin
					// empty payload: checksum closes the frame at once
					job.bytes[3]    = 8'd0 - total[7:0];
					job.last_idx    = lccf_pkg::IDX_W'(3);
					job.end_on_last = 1'b1;
					running_sum_d   = 8'd0;
				end else begin
					job.last_idx    = lccf_pkg::IDX_W'(2);
					job.end_on_last = 1'b0;
					in_frame_d      = 1'b1;
					running_sum_d   = total[7:0];
				end
			end
		end else if (!in_frame_q) begin
			job.status = lccf_pkg::ST_IDLE_DATA;
		end else begin
			job.bytes[0] = in_chan.data_byte;
			bytes_left_d = left_dec;
			if (left_dec == 16'd0) begin
				job.bytes[1]    = 8'd0 - sum_data;
				job.last_idx    = lccf_pkg::IDX_W'(1);
				job.end_on_last = 1'b1;
				in_frame_d      = 1'b0;
				running_sum_d   = 8'd0;
			end else begin
				job.end_on_last = 1'b0;
				running_sum_d   = sum_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			bytes_left_q  <= '0;
			running_sum_q <= '0;
		end else if (accept) begin
			in_frame_q    <= in_frame_d;
			bytes_left_q  <= bytes_left_d;
			running_sum_q <= running_sum_d;
		end
	end

	`LCCF_ASSERT_SAME(a_frame_has_bytes, clk, arst_n, 1'b1, in_frame_q == (bytes_left_q != 16'd0))
	`LCCF_ASSERT_SAME(a_idle_sum_clear, clk, arst_n, !in_frame_q, running_sum_q == 8'd0)

endmodule

@@ rtl/lccf_queue.sv @@
// short job queue between the front end and the byte sequencer
// depends on lccf_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "length_command_checksum_framer_unit_assert.svh"

module lccf_queue #(
	parameter int QueueDepth = lccf_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lccf_pkg::job_t      push_job,
	input  logic                pop,
	output logic                head_valid,
	output lccf_pkg::job_t      head
);

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

	lccf_pkg::job_t mem_q [QueueDepth];

	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == FullCnt);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`LCCF_ASSERT_SAME(a_no_push_when_full, clk, arst_n, full, !do_push)
	`LCCF_ASSERT_SAME(a_count_bounded, clk, arst_n, 1'b1, count_q <= FullCnt)

endmodule

@@ rtl/lccf_back.sv @@
// back end: walks the head job byte by byte into the output register
// depends on lccf_pkg, lccf_if and the assertion macro header
`timescale 1ns / 1ps
`include "length_command_checksum_framer_unit_assert.svh"

module lccf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  lccf_pkg::job_t head,
	output logic           pop,
	lccf_out_if.source     out_chan
);

	logic [lccf_pkg::IDX_W-1:0] idx_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       frame_end_q;
	logic [1:0]                 status_q;
	logic                       load;
	logic                       take;
	logic                       is_last;

	assign load    = !out_valid_q || out_chan.ready;
	assign take    = load && head_valid;
	assign is_last = (idx_q == head.last_idx);
	assign pop     = take && is_last;

	assign out_chan.valid     = out_valid_q;
	assign out_chan.out_byte  = out_byte_q;
	assign out_chan.frame_end = frame_end_q;
	assign out_chan.status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (take) begin
				idx_q <= is_last ? '0 : idx_q + lccf_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q  <= head.bytes[idx_q];
			frame_end_q <= is_last && head.end_on_last;
			status_q    <= head.status;
		end
	end

	`LCCF_ASSERT_SAME(a_idx_within_job, clk, arst_n, idx_q != '0,
		head_valid && (idx_q <= head.last_idx))
	`LCCF_ASSERT_NEXT(a_take_shows_valid, clk, arst_n, take, out_valid_q)

endmodule

@@ rtl/length_command_checksum_framer_unit.sv @@
// Length/command/checksum framer. A start request opens a frame and yields the
// 16-bit total length (payload plus 4, high byte first) and the command byte;
// each payload request passes its byte through, and the last one is followed by
// the checksum byte (two's complement of the low length byte plus all payload
// bytes). Error requests yield one zero byte with frame_end set and a status code.
// The front end accepts one request per cycle while its job queue (QueueDepth
// entries) has room; each request makes a job of one to four bytes, and the back
// end sends one byte per cycle while the output is ready, so a start request yields
// three or four output bytes. An accepted request is stored in the queue, and the
// back end then loads its first byte into the output register.
// depends on lccf_pkg, lccf_if, lccf_front, lccf_queue, lccf_back
`timescale 1ns / 1ps

module length_command_checksum_framer_unit #(
	parameter int QueueDepth = lccf_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	lccf_in_if.sink     in_chan,
	lccf_out_if.source  out_chan
);

	logic                push;
	logic                full;
	lccf_pkg::job_t      new_job;
	lccf_pkg::job_t      head_job;
	logic                head_valid;
	logic                pop;

	lccf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_chan (in_chan),
		.full    (full),
		.push    (push),
		.job     (new_job)
	);

	lccf_queue #(
		.QueueDepth (QueueDepth)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.push_job    (new_job),
		.pop         (pop),
		.head_valid  (head_valid),
		.head        (head_job)
	);

	lccf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head_job),
		.pop        (pop),
		.out_chan   (out_chan)
	);

endmodule

@@ sim/length_command_checksum_framer_unit_checker.sv @@
// checker for the length/command/checksum framer: watches both request channels,
// predicts the framed byte stream and compares it result by result
// depends on lccf_pkg and lccf_if
`timescale 1ns / 1ps

module length_command_checksum_framer_unit_checker (
	input  logic clk,
	input  logic arst_n,
	lccf_in_if   in_mon,
	lccf_out_if  out_mon,
	output int   fail_count,
	output int   pending,
	output int   results_seen,
	output int   frames_closed,
	output int   error_results
);

	localparam logic [16:0] MAX_TOTAL = 17'h0ffff;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [7:0]         out_byte;
		logic               frame_end;
		lccf_pkg::status_t  status;
	} bus_byte_t;

	bus_byte_t   framed_bytes[$];
	logic        open_frame = 1'b0;
	logic [15:0] bytes_due = '0;
	logic [7:0]  byte_sum = '0;

	function automatic bus_byte_t bus_byte(logic [7:0] b, logic e, lccf_pkg::status_t s);
		bus_byte_t r;
		r.out_byte = b;
		r.frame_end = e;
		r.status = s;
		return r;
	endfunction

	function automatic logic [7:0] checksum_of(logic [7:0] s);
		return 8'h00 - s;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_CAP) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	task automatic frame_request(input logic start, input logic [7:0] cmd,
		input logic [15:0] plen, input logic [7:0] data);
		logic [16:0] total;
		total = {1'b0, plen} + lccf_pkg::HDR_EXTRA;
		if (start) begin
			if (open_frame) begin
				framed_bytes.push_back(bus_byte(8'h00, 1'b1, lccf_pkg::ST_BUSY));
			end else if (total > MAX_TOTAL) begin
				framed_bytes.push_back(bus_byte(8'h00, 1'b1, lccf_pkg::ST_SIZE));
			end else begin
				framed_bytes.push_back(bus_byte(total[15:8], 1'b0, lccf_pkg::ST_OK));
				framed_bytes.push_back(bus_byte(total[7:0], 1'b0, lccf_pkg::ST_OK));
				framed_bytes.push_back(bus_byte(cmd, 1'b0, lccf_pkg::ST_OK));
				byte_sum = total[7:0];
				bytes_due = plen;
				if (plen == 16'd0) begin
					framed_bytes.push_back(bus_byte(checksum_of(byte_sum), 1'b1,
						lccf_pkg::ST_OK));
					byte_sum = '0;
				end else begin
					open_frame = 1'b1;
				end
			end
		end else if (!open_frame) begin
			framed_bytes.push_back(bus_byte(8'h00, 1'b1, lccf_pkg::ST_IDLE_DATA));
		end else begin
			framed_bytes.push_back(bus_byte(data, 1'b0, lccf_pkg::ST_OK));
			byte_sum = byte_sum + data;
			bytes_due = bytes_due - 16'd1;
			if (bytes_due == 16'd0) begin
				framed_bytes.push_back(bus_byte(checksum_of(byte_sum), 1'b1,
					lccf_pkg::ST_OK));
				open_frame = 1'b0;
				byte_sum = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bus_byte_t want;
		if (!arst_n) begin
			framed_bytes.delete();
			open_frame = 1'b0;
			bytes_due = '0;
			byte_sum = '0;
			pending = 0;
		end else begin
			if (in_mon.valid && in_mon.ready) begin
				frame_request(in_mon.start_req, in_mon.command, in_mon.payload_len,
					in_mon.data_byte);
			end
			if (out_mon.valid && out_mon.ready) begin
				results_seen++;
				if (framed_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %h end %b code %0d",
						out_mon.out_byte, out_mon.frame_end, out_mon.status));
				end else begin
					want = framed_bytes.pop_front();
					if (out_mon.out_byte !== want.out_byte
						|| out_mon.frame_end !== want.frame_end
						|| out_mon.status !== want.status) begin
						report_mismatch($sformatf(
							"byte %h want %h, end %b want %b, code %0d want %0d",
							out_mon.out_byte, want.out_byte, out_mon.frame_end,
							want.frame_end, out_mon.status, want.status));
					end
					if (want.status != lccf_pkg::ST_OK) begin
						error_results++;
					end else if (want.frame_end) begin
						frames_closed++;
					end
				end
			end
			pending = framed_bytes.size();
		end
	end

endmodule

@@ sim/length_command_checksum_framer_unit_tb.sv @@
// testbench top for the length/command/checksum framer: drives start and payload
// requests with random gaps and output stalls, then gives the verdict
// depends on lccf_pkg, lccf_if, the framer rtl and the framer checker
`timescale 1ns / 1ps

module length_command_checksum_framer_unit_tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD = 90;
	localparam logic [15:0] MAX_PAYLOAD = 16'd65531;
	localparam logic [15:0] OVERSIZE_BASE = 16'd65532;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int fail_count;
	int pending;
	int results_seen;
	int frames_closed;
	int error_results;
	int cycle_count = 0;
	int sent_items = 0;
	int random_frames = 0;
	int src_gap_pct = 0;
	int sink_stall_pct = 0;
	bit hold_req = 1'b0;

	lccf_in_if  in_chan();
	lccf_out_if out_chan();

	length_command_checksum_framer_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_chan (in_chan),
		.out_chan(out_chan)
	);

	length_command_checksum_framer_unit_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_mon       (in_chan),
		.out_mon      (out_chan),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.frames_closed(frames_closed),
		.error_results(error_results)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("status: fail");
		$finish;
	end

	// output side: random stall bursts, plus one long hold-off on request
	initial begin
		out_chan.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_chan.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (sink_stall_pct > 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
				out_chan.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_chan.ready <= 1'b1;
		end
	end

	task automatic send_req(input logic start, input logic [7:0] cmd,
		input logic [15:0] plen, input logic [7:0] data);
		if (src_gap_pct > 0 && $urandom_range(1, 100) <= src_gap_pct) begin
			in_chan.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_chan.valid <= 1'b1;
		in_chan.start_req <= start;
		in_chan.command <= cmd;
		in_chan.payload_len <= plen;
		in_chan.data_byte <= data;
		do @(posedge clk); while (!in_chan.ready);
		sent_items++;
	endtask

	task automatic send_start(input logic [7:0] cmd, input logic [15:0] plen);
		send_req(1'b1, cmd, plen, 8'($urandom));
	endtask

	task automatic send_data(input logic [7:0] data);
		send_req(1'b0, 8'($urandom), 16'($urandom), data);
	endtask

	// one frame with random content; noise_pct injects starts inside the open frame
	task automatic send_frame(input logic [15:0] len, input int noise_pct);
		send_start(8'($urandom), len);
		for (int i = 0; i < len; i++) begin
			if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct) begin
				send_start(8'($urandom), 16'($urandom));
			end
			send_data(8'($urandom));
		end
	endtask

	task automatic random_traffic(input int n_items);
		int stop_at;
		int pick;
		int len;
		stop_at = sent_items + n_items;
		while (sent_items < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_data(8'($urandom));
			end else if (pick < 11) begin
				send_start(8'($urandom), OVERSIZE_BASE + 16'($urandom_range(0, 3)));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					len = $urandom_range(0, 6);
				end else if (pick < 95) begin
					len = $urandom_range(7, 24);
				end else begin
					len = $urandom_range(25, 60);
				end
				send_frame(16'(len), 8);
				random_frames++;
			end
		end
	endtask

	initial begin
		in_chan.valid <= 1'b0;
		in_chan.start_req <= 1'b0;
		in_chan.command <= '0;
		in_chan.payload_len <= '0;
		in_chan.data_byte <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray payload, empty frames, oversize, busy starts, short frames
		src_gap_pct = 20;
		sink_stall_pct = 10;
		send_data(8'h00);
		send_data(8'hff);
		send_start(8'h00, 16'd0);
		send_start(8'hff, 16'd0);
		send_start(8'h5a, OVERSIZE_BASE);
		send_start(8'ha5, 16'hffff);
		send_start(8'h11, 16'd3);
		send_data(8'hff);
		send_start(8'h22, 16'hffff);
		send_data(8'h00);
		send_start(8'h33, 16'd0);
		send_data(8'h80);
		send_start(8'hc3, 16'd1);
		send_data(8'h3c);
		send_start(8'h01, 16'd2);
		send_data(8'h7f);
		send_data(8'h01);
		send_data(8'h55);

		src_gap_pct = 25;
		sink_stall_pct = 15;
		random_traffic(40);

		// long output hold-off while the input keeps offering a frame
		hold_req = 1'b1;
		send_frame(16'd24, 0);

		src_gap_pct = 10;
		sink_stall_pct = 30;
		random_traffic(40);

		// no idling on either side from here on
		src_gap_pct = 0;
		sink_stall_pct = 0;
		random_traffic(35);

		// largest legal total length, then a busy start and a payload byte
		send_start(8'h96, MAX_PAYLOAD);
		send_start(8'h69, 16'd0);
		send_data(8'h5a);
		in_chan.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d requests incl. %0d random frames and a maximum-length header",
			sent_items, random_frames);
		$display("checked %0d bus bytes: %0d frames closed, %0d error results",
			results_seen, frames_closed, error_results);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lccf_pkg.sv
rtl/lccf_if.sv
rtl/lccf_front.sv
rtl/lccf_queue.sv
rtl/lccf_back.sv
rtl/length_command_checksum_framer_unit.sv
sim/length_command_checksum_framer_unit_checker.sv
sim/length_command_checksum_framer_unit_tb.sv
